>>> src/lcs_pkg.sv
// Package for the link connect supervisor: state and status codes,
// opcodes, register indexes and the structs shared by the modules.
// No dependencies.
package lcs_pkg;

  typedef enum logic [2:0] {
    ST_DISABLED   = 3'd0,
    ST_IDLE       = 3'd1,
    ST_CONNECTING = 3'd2,
    ST_CONNECTED  = 3'd3,
    ST_BACKOFF    = 3'd4
  } sup_state_t;

  localparam logic [2:0] LS_DOWN       = 3'd0;
  localparam logic [2:0] LS_CONNECTING = 3'd1;
  localparam logic [2:0] LS_UP         = 3'd2;
  localparam logic [2:0] LS_MAX        = 3'd4;

  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_SUSPEND = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;

  localparam int unsigned ADDR_W = 5;

  localparam logic [2:0] REG_LINK_ENABLED   = 3'd0;
  localparam logic [2:0] REG_CREDENTIALS_OK = 3'd1;
  localparam logic [2:0] REG_NETWORK_NAMED  = 3'd2;
  localparam logic [2:0] REG_CONNECT_TMO    = 3'd3;
  localparam logic [2:0] REG_RETRY_BACKOFF  = 3'd4;
  localparam logic [2:0] REG_POLL_INTERVAL  = 3'd5;

  localparam logic [31:0] CONNECT_TMO_RESET   = 32'd15000;
  localparam logic [31:0] RETRY_BACKOFF_RESET = 32'd5000;
  localparam logic [31:0] POLL_INTERVAL_RESET = 32'd250;
  localparam logic [31:0] MIN_INTERVAL        = 32'd1;

  typedef struct packed {
    logic        link_enabled;
    logic        credentials_ok;
    logic        network_named;
    logic [31:0] connect_timeout_ms;
    logic [31:0] retry_backoff_ms;
    logic [31:0] poll_interval_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] now_ms;
    logic [2:0]  radio_status;
    logic        begin_accepted;
  } item_t;

  typedef struct packed {
    sup_state_t  fsm;
    logic [2:0]  latch;
    logic [31:0] attempts;
    logic [31:0] timeouts;
    logic [31:0] drops;
    logic [31:0] last_change;
    logic [31:0] attempt_start;
    logic [31:0] backoff_end;
    logic [31:0] last_sample;
    logic [31:0] up_since;
  } sup_t;

  typedef struct packed {
    logic [2:0]  supervisor_state;
    logic [2:0]  held_link_status;
    logic        link_up;
    logic        issue_begin;
    logic        issue_disconnect;
    logic [31:0] attempt_count;
    logic [31:0] timeout_count;
    logic [31:0] drop_count;
    logic [31:0] transition_time;
    logic [31:0] retry_time;
    logic [31:0] up_since_time;
  } result_t;

endpackage

>>> src/link_connect_supervisor_unit.sv
// Link connect supervisor: input word register, supervisor state and result
// register around the step logic. Depends on lcs_pkg, lcs_cfg and lcs_step.
//
// Usage:
//   Input channel (item_valid/item_ready) carries one word: opcode (tick,
//   suspend, clear counters), now_ms, radio_status and begin_accepted.
//   Result channel (result_valid/result_ready) returns exactly one word per
//   input word: state, latched link status, command flags, the three counts
//   and the recorded timestamps, all as they stand after that input word.
//   Path: an accepted word is held in the input register; its result is
//   written to the result register once that register is free to take it.
//   Throughput: one word per cycle while result_ready is held high; the state
//   update is a single pass of compares, 32-bit adds and increments between
//   the input register and the result register.
//   Stall: while the result waits, one more word is held in the input
//   register; then item_ready drops until result_ready frees the output.
//   Reset (rst, synchronous): both registers empty, state disabled, link
//   status down, counts and times zero, configuration at its defaults.
//   Configuration registers are to be written through the APB-style port
//   only while the block is idle (not enforced); pready is always high.
module link_connect_supervisor_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lcs_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       item_valid,
  output logic                       item_ready,
  input  logic [1:0]                 opcode,
  input  logic [31:0]                now_ms,
  input  logic [2:0]                 radio_status,
  input  logic                       begin_accepted,
  output logic                       result_valid,
  input  logic                       result_ready,
  output logic [2:0]                 supervisor_state,
  output logic [2:0]                 held_link_status,
  output logic                       link_up,
  output logic                       issue_begin,
  output logic                       issue_disconnect,
  output logic [31:0]                attempt_count,
  output logic [31:0]                timeout_count,
  output logic [31:0]                drop_count,
  output logic [31:0]                transition_time,
  output logic [31:0]                retry_time,
  output logic [31:0]                up_since_time
);
  import lcs_pkg::*;

  cfg_t    cfg;
  item_t   item_q;
  logic    item_full;
  sup_t    sup;
  sup_t    sup_next;
  result_t res_next;
  result_t res_q;
  logic    advance;

  assign pready     = 1'b1;
  assign advance    = item_full && (!result_valid || result_ready);
  assign item_ready = !item_full || advance;

  lcs_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  lcs_step u_step (
    .cfg    (cfg),
    .item   (item_q),
    .cur    (sup),
    .nxt    (sup_next),
    .result (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_full <= 1'b0;
    end else if (item_ready) begin
      item_full <= item_valid;
    end
    if (item_ready) begin
      item_q.opcode         <= opcode;
      item_q.now_ms         <= now_ms;
      item_q.radio_status   <= radio_status;
      item_q.begin_accepted <= begin_accepted;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sup.fsm           <= ST_DISABLED;
      sup.latch         <= LS_DOWN;
      sup.attempts      <= '0;
      sup.timeouts      <= '0;
      sup.drops         <= '0;
      sup.last_change   <= '0;
      sup.attempt_start <= '0;
      sup.backoff_end   <= '0;
      sup.last_sample   <= '0;
      sup.up_since      <= '0;
    end else if (advance) begin
      sup <= sup_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
    if (advance) begin
      res_q <= res_next;
    end
  end

  assign supervisor_state = res_q.supervisor_state;
  assign held_link_status = res_q.held_link_status;
  assign link_up          = res_q.link_up;
  assign issue_begin      = res_q.issue_begin;
  assign issue_disconnect = res_q.issue_disconnect;
  assign attempt_count    = res_q.attempt_count;
  assign timeout_count    = res_q.timeout_count;
  assign drop_count       = res_q.drop_count;
  assign transition_time  = res_q.transition_time;
  assign retry_time       = res_q.retry_time;
  assign up_since_time    = res_q.up_since_time;

endmodule

>>> src/lcs_cfg.sv
// Configuration register file behind the APB-style port.
// Depends on lcs_pkg for register indexes, reset values and cfg_t.
module lcs_cfg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [lcs_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output lcs_pkg::cfg_t             cfg
);
  import lcs_pkg::*;

  logic [2:0]  index;
  logic        wr_en;
  logic [31:0] wdata_min1;

  assign index      = paddr[ADDR_W-1:2];
  assign wr_en      = psel && penable && pwrite;
  assign wdata_min1 = (pwdata == '0) ? MIN_INTERVAL : pwdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.link_enabled       <= 1'b0;
      cfg.credentials_ok     <= 1'b0;
      cfg.network_named      <= 1'b0;
      cfg.connect_timeout_ms <= CONNECT_TMO_RESET;
      cfg.retry_backoff_ms   <= RETRY_BACKOFF_RESET;
      cfg.poll_interval_ms   <= POLL_INTERVAL_RESET;
    end else if (wr_en) begin
      case (index)
        REG_LINK_ENABLED:   cfg.link_enabled       <= pwdata[0];
        REG_CREDENTIALS_OK: cfg.credentials_ok     <= pwdata[0];
        REG_NETWORK_NAMED:  cfg.network_named      <= pwdata[0];
        REG_CONNECT_TMO:    cfg.connect_timeout_ms <= wdata_min1;
        REG_RETRY_BACKOFF:  cfg.retry_backoff_ms   <= pwdata;
        REG_POLL_INTERVAL:  cfg.poll_interval_ms   <= wdata_min1;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (index)
      REG_LINK_ENABLED:   prdata = {31'd0, cfg.link_enabled};
      REG_CREDENTIALS_OK: prdata = {31'd0, cfg.credentials_ok};
      REG_NETWORK_NAMED:  prdata = {31'd0, cfg.network_named};
      REG_CONNECT_TMO:    prdata = cfg.connect_timeout_ms;
      REG_RETRY_BACKOFF:  prdata = cfg.retry_backoff_ms;
      REG_POLL_INTERVAL:  prdata = cfg.poll_interval_ms;
      default:            prdata = '0;
    endcase
  end

endmodule

>>> src/lcs_step.sv
// Next-state and result logic for one word: tick, suspend or counter clear.
// Depends on lcs_pkg for codes and the cfg_t, item_t, sup_t, result_t structs.
module lcs_step (
  input  lcs_pkg::cfg_t    cfg,
  input  lcs_pkg::item_t   item,
  input  lcs_pkg::sup_t    cur,
  output lcs_pkg::sup_t    nxt,
  output lcs_pkg::result_t result
);
  import lcs_pkg::*;

  logic [2:0]  radio;
  logic        ready_ok;
  sup_state_t  fsm_run;
  logic        do_attempt;
  logic        do_backoff;
  logic        cmd_begin;
  logic        cmd_disc;
  logic [31:0] now;
  logic [31:0] since_sample;
  logic [31:0] since_attempt;
  logic [31:0] past_backoff;

  assign now           = item.now_ms;
  assign radio         = (item.radio_status > LS_MAX) ? LS_DOWN : item.radio_status;
  assign ready_ok      = cfg.link_enabled && cfg.credentials_ok && cfg.network_named;
  assign since_sample  = now - cur.last_sample;
  assign since_attempt = now - cur.attempt_start;
  assign past_backoff  = now - cur.backoff_end;

  always_comb begin
    nxt        = cur;
    fsm_run    = cur.fsm;
    do_attempt = 1'b0;
    do_backoff = 1'b0;
    cmd_begin  = 1'b0;
    cmd_disc   = 1'b0;
    case (item.opcode)
      OP_TICK: begin
        if (!ready_ok) begin
          if (cur.fsm != ST_DISABLED) begin
            cmd_disc        = 1'b1;
            nxt.drops       = cur.drops + 32'd1;
            nxt.fsm         = ST_DISABLED;
            nxt.last_change = now;
          end
          nxt.latch    = LS_DOWN;
          nxt.up_since = '0;
        end else begin
          if (cur.fsm == ST_DISABLED) begin
            fsm_run         = ST_IDLE;
            nxt.fsm         = ST_IDLE;
            nxt.last_change = now;
          end
          if (since_sample >= cfg.poll_interval_ms) begin
            nxt.last_sample = now;
            nxt.latch       = radio;
          end
          case (fsm_run)
            ST_IDLE: do_attempt = 1'b1;
            ST_CONNECTING: begin
              if (nxt.latch == LS_UP) begin
                nxt.up_since    = now;
                nxt.fsm         = ST_CONNECTED;
                nxt.last_change = now;
              end else if (since_attempt >= cfg.connect_timeout_ms) begin
                nxt.timeouts = cur.timeouts + 32'd1;
                do_backoff   = 1'b1;
              end
            end
            ST_CONNECTED: begin
              if (nxt.latch != LS_UP) begin
                nxt.drops  = cur.drops + 32'd1;
                do_backoff = 1'b1;
              end
            end
            ST_BACKOFF: do_attempt = !past_backoff[31];
            default: ;
          endcase
          if (do_attempt) begin
            nxt.attempts      = cur.attempts + 32'd1;
            nxt.attempt_start = now;
            nxt.last_sample   = now;
            nxt.latch         = radio;
            cmd_begin         = 1'b1;
            if (!item.begin_accepted) begin
              do_backoff = 1'b1;
            end else if (nxt.fsm != ST_CONNECTING) begin
              nxt.fsm         = ST_CONNECTING;
              nxt.last_change = now;
            end
          end
          if (do_backoff) begin
            cmd_disc        = 1'b1;
            nxt.up_since    = '0;
            nxt.backoff_end = now + cfg.retry_backoff_ms;
            nxt.latch       = radio;
            if (nxt.fsm != ST_BACKOFF) begin
              nxt.fsm         = ST_BACKOFF;
              nxt.last_change = now;
            end
          end
        end
      end
      OP_SUSPEND: begin
        cmd_disc          = (cur.fsm != ST_DISABLED);
        nxt.fsm           = ST_DISABLED;
        nxt.latch         = LS_DOWN;
        nxt.up_since      = '0;
        nxt.attempt_start = '0;
        nxt.backoff_end   = '0;
        nxt.last_sample   = '0;
      end
      OP_CLEAR: begin
        nxt.attempts = '0;
        nxt.timeouts = '0;
        nxt.drops    = '0;
      end
      default: ;
    endcase
  end

  always_comb begin
    result.supervisor_state = nxt.fsm;
    result.held_link_status = nxt.latch;
    result.link_up          = (nxt.fsm == ST_CONNECTED) && (nxt.latch == LS_UP);
    result.issue_begin      = cmd_begin;
    result.issue_disconnect = cmd_disc;
    result.attempt_count    = nxt.attempts;
    result.timeout_count    = nxt.timeouts;
    result.drop_count       = nxt.drops;
    result.transition_time  = nxt.last_change;
    result.retry_time       = nxt.backoff_end;
    result.up_since_time    = nxt.up_since;
  end

endmodule

>>> test/link_supervisor_checker.sv
// Checker for the link connect supervisor: watches the APB port and both word
// channels, predicts every result word and compares it field by field.
// Depends on lcs_pkg.
`timescale 1ns / 1ps

module link_supervisor_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lcs_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  input  logic [31:0]                prdata,
  input  logic                       pready,
  input  logic                       item_valid,
  input  logic                       item_ready,
  input  logic [1:0]                 opcode,
  input  logic [31:0]                now_ms,
  input  logic [2:0]                 radio_status,
  input  logic                       begin_accepted,
  input  logic                       result_valid,
  input  logic                       result_ready,
  input  logic [2:0]                 supervisor_state,
  input  logic [2:0]                 held_link_status,
  input  logic                       link_up,
  input  logic                       issue_begin,
  input  logic                       issue_disconnect,
  input  logic [31:0]                attempt_count,
  input  logic [31:0]                timeout_count,
  input  logic [31:0]                drop_count,
  input  logic [31:0]                transition_time,
  input  logic [31:0]                retry_time,
  input  logic [31:0]                up_since_time,
  output int                         errors,
  output int                         pending,
  output int                         checked,
  output logic [4:0]                 states_seen,
  output int                         begins_seen,
  output int                         disconnects_seen
);
  import lcs_pkg::*;

  cfg_t       cfg;
  sup_t       sup;
  logic [2:0] radio_now;
  logic       accept_now;
  logic       begin_flag;
  logic       disc_flag;
  result_t    report_q[$];
  result_t    want;
  item_t      word_in;

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (exp_v !== got_v) begin
      errors++;
      if (errors <= 10)
        $display("word %0d: %s expected %0h got %0h", checked, name, exp_v, got_v);
    end
  endfunction

  function automatic void move_to(sup_state_t s, logic [31:0] t);
    if (sup.fsm != s) begin
      sup.fsm = s;
      sup.last_change = t;
    end
  endfunction

  function automatic void start_backoff(logic [31:0] t);
    disc_flag = 1'b1;
    sup.up_since = '0;
    sup.backoff_end = t + cfg.retry_backoff_ms;
    sup.latch = radio_now;
    move_to(ST_BACKOFF, t);
  endfunction

  function automatic void start_attempt(logic [31:0] t);
    sup.attempts = sup.attempts + 32'd1;
    sup.attempt_start = t;
    sup.last_sample = t;
    sup.latch = LS_CONNECTING;
    begin_flag = 1'b1;
    if (!accept_now) begin
      start_backoff(t);
    end else begin
      sup.latch = radio_now;
      move_to(ST_CONNECTING, t);
    end
  endfunction

  function automatic void run_tick(logic [31:0] t);
    logic [31:0] since_end;
    if (!(cfg.link_enabled && cfg.credentials_ok && cfg.network_named)) begin
      if (sup.fsm != ST_DISABLED) begin
        disc_flag = 1'b1;
        sup.drops = sup.drops + 32'd1;
      end
      sup.latch = LS_DOWN;
      sup.up_since = '0;
      move_to(ST_DISABLED, t);
    end else begin
      if (sup.fsm == ST_DISABLED) move_to(ST_IDLE, t);
      if (t - sup.last_sample >= cfg.poll_interval_ms) begin
        sup.last_sample = t;
        sup.latch = radio_now;
      end
      since_end = t - sup.backoff_end;
      case (sup.fsm)
        ST_IDLE: begin
          start_attempt(t);
        end
        ST_CONNECTING: begin
          if (sup.latch == LS_UP) begin
            sup.up_since = t;
            move_to(ST_CONNECTED, t);
          end else if (t - sup.attempt_start >= cfg.connect_timeout_ms) begin
            sup.timeouts = sup.timeouts + 32'd1;
            start_backoff(t);
          end
        end
        ST_CONNECTED: begin
          if (sup.latch != LS_UP) begin
            sup.drops = sup.drops + 32'd1;
            start_backoff(t);
          end
        end
        ST_BACKOFF: begin
          if (!since_end[31]) start_attempt(t);
        end
        default: ;
      endcase
    end
  endfunction

  function automatic result_t step_supervisor(item_t w);
    result_t r;
    radio_now = (w.radio_status > LS_MAX) ? LS_DOWN : w.radio_status;
    accept_now = w.begin_accepted;
    begin_flag = 1'b0;
    disc_flag = 1'b0;
    case (w.opcode)
      OP_TICK: run_tick(w.now_ms);
      OP_SUSPEND: begin
        if (sup.fsm != ST_DISABLED) disc_flag = 1'b1;
        sup.fsm = ST_DISABLED;
        sup.latch = LS_DOWN;
        sup.up_since = '0;
        sup.attempt_start = '0;
        sup.backoff_end = '0;
        sup.last_sample = '0;
      end
      OP_CLEAR: begin
        sup.attempts = '0;
        sup.timeouts = '0;
        sup.drops = '0;
      end
      default: ;
    endcase
    r.supervisor_state = sup.fsm;
    r.held_link_status = sup.latch;
    r.link_up = (sup.fsm == ST_CONNECTED) && (sup.latch == LS_UP);
    r.issue_begin = begin_flag;
    r.issue_disconnect = disc_flag;
    r.attempt_count = sup.attempts;
    r.timeout_count = sup.timeouts;
    r.drop_count = sup.drops;
    r.transition_time = sup.last_change;
    r.retry_time = sup.backoff_end;
    r.up_since_time = sup.up_since;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      cfg.link_enabled = 1'b0;
      cfg.credentials_ok = 1'b0;
      cfg.network_named = 1'b0;
      cfg.connect_timeout_ms = CONNECT_TMO_RESET;
      cfg.retry_backoff_ms = RETRY_BACKOFF_RESET;
      cfg.poll_interval_ms = POLL_INTERVAL_RESET;
      sup = '0;
      sup.fsm = ST_DISABLED;
      sup.latch = LS_DOWN;
      report_q.delete();
      errors = 0;
      checked = 0;
      states_seen = '0;
      begins_seen = 0;
      disconnects_seen = 0;
    end else begin
      if (psel && penable && pready && pwrite) begin
        case (paddr[lcs_pkg::ADDR_W-1:2])
          REG_LINK_ENABLED:   cfg.link_enabled = pwdata[0];
          REG_CREDENTIALS_OK: cfg.credentials_ok = pwdata[0];
          REG_NETWORK_NAMED:  cfg.network_named = pwdata[0];
          REG_CONNECT_TMO:    cfg.connect_timeout_ms = (pwdata == '0) ? MIN_INTERVAL : pwdata;
          REG_RETRY_BACKOFF:  cfg.retry_backoff_ms = pwdata;
          REG_POLL_INTERVAL:  cfg.poll_interval_ms = (pwdata == '0) ? MIN_INTERVAL : pwdata;
          default: ;
        endcase
      end
      if (psel && penable && pready && !pwrite) begin
        case (paddr[lcs_pkg::ADDR_W-1:2])
          REG_LINK_ENABLED:   check_field("link_enabled", {31'b0, cfg.link_enabled}, prdata);
          REG_CREDENTIALS_OK: check_field("credentials_ok", {31'b0, cfg.credentials_ok}, prdata);
          REG_NETWORK_NAMED:  check_field("network_named", {31'b0, cfg.network_named}, prdata);
          REG_CONNECT_TMO:    check_field("connect_timeout_ms", cfg.connect_timeout_ms, prdata);
          REG_RETRY_BACKOFF:  check_field("retry_backoff_ms", cfg.retry_backoff_ms, prdata);
          REG_POLL_INTERVAL:  check_field("poll_interval_ms", cfg.poll_interval_ms, prdata);
          default: ;
        endcase
      end
      if (result_valid && result_ready) begin
        if (report_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result word after %0d checked", checked);
        end else begin
          want = report_q.pop_front();
          check_field("supervisor_state", 32'(want.supervisor_state), 32'(supervisor_state));
          check_field("held_link_status", 32'(want.held_link_status), 32'(held_link_status));
          check_field("link_up", 32'(want.link_up), 32'(link_up));
          check_field("issue_begin", 32'(want.issue_begin), 32'(issue_begin));
          check_field("issue_disconnect", 32'(want.issue_disconnect), 32'(issue_disconnect));
          check_field("attempt_count", want.attempt_count, attempt_count);
          check_field("timeout_count", want.timeout_count, timeout_count);
          check_field("drop_count", want.drop_count, drop_count);
          check_field("transition_time", want.transition_time, transition_time);
          check_field("retry_time", want.retry_time, retry_time);
          check_field("up_since_time", want.up_since_time, up_since_time);
          checked++;
          if (want.supervisor_state <= ST_BACKOFF) states_seen[want.supervisor_state] = 1'b1;
          if (want.issue_begin) begins_seen++;
          if (want.issue_disconnect) disconnects_seen++;
        end
      end
      if (item_valid && item_ready) begin
        word_in.opcode = opcode;
        word_in.now_ms = now_ms;
        word_in.radio_status = radio_status;
        word_in.begin_accepted = begin_accepted;
        report_q.push_back(step_supervisor(word_in));
      end
    end
    pending = report_q.size();
  end

endmodule

>>> test/link_connect_supervisor_unit_test.sv
// Top of the link connect supervisor testbench: clock, reset, APB setup and
// word stimulus, verdict. Depends on lcs_pkg, link_connect_supervisor_unit
// and link_supervisor_checker.
`timescale 1ns / 1ps

module link_connect_supervisor_unit_test;
  import lcs_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         CYCLE_LIMIT = 300000;

  logic                clk = 1'b0;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;
  logic                item_valid;
  logic                item_ready;
  logic [1:0]          opcode;
  logic [31:0]         now_ms;
  logic [2:0]          radio_status;
  logic                begin_accepted;
  logic                result_valid;
  logic                result_ready;
  logic [2:0]          supervisor_state;
  logic [2:0]          held_link_status;
  logic                link_up;
  logic                issue_begin;
  logic                issue_disconnect;
  logic [31:0]         attempt_count;
  logic [31:0]         timeout_count;
  logic [31:0]         drop_count;
  logic [31:0]         transition_time;
  logic [31:0]         retry_time;
  logic [31:0]         up_since_time;

  int                  errors;
  int                  pending;
  int                  checked;
  logic [4:0]          states_seen;
  int                  begins_seen;
  int                  disconnects_seen;
  int                  cycle_count = 0;
  int                  settings_used = 0;
  bit                  gaps_on = 1'b1;
  logic [31:0]         clock_ms;
  logic [2:0]          air;

  link_connect_supervisor_unit u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .item_valid(item_valid), .item_ready(item_ready),
    .opcode(opcode), .now_ms(now_ms), .radio_status(radio_status),
    .begin_accepted(begin_accepted),
    .result_valid(result_valid), .result_ready(result_ready),
    .supervisor_state(supervisor_state), .held_link_status(held_link_status),
    .link_up(link_up), .issue_begin(issue_begin), .issue_disconnect(issue_disconnect),
    .attempt_count(attempt_count), .timeout_count(timeout_count), .drop_count(drop_count),
    .transition_time(transition_time), .retry_time(retry_time),
    .up_since_time(up_since_time)
  );

  link_supervisor_checker u_check (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .item_valid(item_valid), .item_ready(item_ready),
    .opcode(opcode), .now_ms(now_ms), .radio_status(radio_status),
    .begin_accepted(begin_accepted),
    .result_valid(result_valid), .result_ready(result_ready),
    .supervisor_state(supervisor_state), .held_link_status(held_link_status),
    .link_up(link_up), .issue_begin(issue_begin), .issue_disconnect(issue_disconnect),
    .attempt_count(attempt_count), .timeout_count(timeout_count), .drop_count(drop_count),
    .transition_time(transition_time), .retry_time(retry_time),
    .up_since_time(up_since_time),
    .errors(errors), .pending(pending), .checked(checked), .states_seen(states_seen),
    .begins_seen(begins_seen), .disconnects_seen(disconnects_seen)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected", cycle_count, pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (!rst) result_ready <= !(gaps_on && $urandom_range(99) < 10);
  end

  task automatic apb_access(logic [2:0] idx, logic wr, logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic configure(logic [2:0] flags, logic [31:0] tmo, logic [31:0] bo,
                           logic [31:0] poll);
    apb_access(REG_LINK_ENABLED, 1'b1, ($urandom & 32'hFFFF_FFFE) | flags[0]);
    apb_access(REG_CREDENTIALS_OK, 1'b1, ($urandom & 32'hFFFF_FFFE) | flags[1]);
    apb_access(REG_NETWORK_NAMED, 1'b1, ($urandom & 32'hFFFF_FFFE) | flags[2]);
    apb_access(REG_CONNECT_TMO, 1'b1, tmo);
    apb_access(REG_RETRY_BACKOFF, 1'b1, bo);
    apb_access(REG_POLL_INTERVAL, 1'b1, poll);
    for (int r = 0; r <= REG_POLL_INTERVAL; r++) apb_access(r[2:0], 1'b0, '0);
    settings_used++;
  endtask

  task automatic send_word(logic [1:0] op, logic [31:0] t, logic [2:0] rs, logic acc);
    @(negedge clk);
    while (gaps_on && $urandom_range(99) < 10) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    opcode <= op;
    now_ms <= t;
    radio_status <= rs;
    begin_accepted <= acc;
    do @(posedge clk); while (!item_ready);
  endtask

  task automatic drain();
    @(negedge clk);
    item_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic run_session(int count, int step_max);
    int          roll;
    logic [1:0]  op;
    logic [2:0]  rs;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      if (roll < 4) begin
        send_word(2'($urandom_range(3)), $urandom, 3'($urandom_range(7)),
                  1'($urandom_range(1)));
      end else begin
        if (roll < 6) op = OP_SUSPEND;
        else if (roll < 8) op = OP_CLEAR;
        else if (roll < 9) op = OP_UNUSED;
        else op = OP_TICK;
        clock_ms = clock_ms + $urandom_range(step_max);
        if ($urandom_range(9) == 0) air = $urandom_range(1) ? LS_UP : 3'($urandom_range(LS_MAX));
        rs = air;
        if ($urandom_range(31) == 0) rs = 3'($urandom_range(7, 5));
        send_word(op, clock_ms, rs, $urandom_range(19) != 0);
      end
    end
  endtask

  initial begin
    logic [2:0]  flags;
    logic [31:0] tmo;
    logic [31:0] bo;
    logic [31:0] poll;
    int          step_max;
    int          count;

    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    item_valid = 1'b0;
    opcode = OP_TICK;
    now_ms = '0;
    radio_status = LS_DOWN;
    begin_accepted = 1'b0;
    result_ready = 1'b0;
    air = LS_UP;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // directed: not configured, then a walk through every state and corner
    send_word(OP_TICK, 32'd0, LS_UP, 1'b1);
    drain();
    configure(3'b111, CONNECT_TMO_RESET, RETRY_BACKOFF_RESET, POLL_INTERVAL_RESET);
    send_word(OP_TICK, 32'd0, LS_DOWN, 1'b1);
    send_word(OP_TICK, 32'd300, LS_UP, 1'b1);
    send_word(OP_TICK, 32'd400, LS_DOWN, 1'b1);
    send_word(OP_TICK, 32'd600, LS_MAX, 1'b1);
    send_word(OP_TICK, 32'd5599, LS_UP, 1'b1);
    send_word(OP_TICK, 32'd5600, 3'd7, 1'b0);
    send_word(OP_TICK, 32'd10600, LS_CONNECTING, 1'b1);
    send_word(OP_TICK, 32'd25600, LS_CONNECTING, 1'b1);
    send_word(OP_CLEAR, 32'hFFFF_FFFF, 3'd7, 1'b1);
    send_word(OP_UNUSED, 32'hFFFF_FFFF, 3'd7, 1'b1);
    send_word(OP_SUSPEND, 32'd0, LS_UP, 1'b0);
    send_word(OP_SUSPEND, 32'hFFFF_FFFF, LS_UP, 1'b1);
    send_word(OP_TICK, 32'hFFFF_FFFF, 3'd5, 1'b1);
    send_word(OP_TICK, 32'h0000_00F0, LS_UP, 1'b1);
    send_word(OP_TICK, 32'h0000_0100, LS_UP, 1'b1);
    drain();
    apb_access(REG_LINK_ENABLED, 1'b1, 32'd0);
    send_word(OP_TICK, 32'h0000_0200, LS_UP, 1'b1);
    send_word(OP_TICK, 32'h0000_0300, LS_UP, 1'b1);
    drain();

    for (int p = 0; p < 12; p++) begin
      flags = 3'b111;
      count = 108;
      case (p)
        0: begin
          tmo = '0;
          bo = '0;
          poll = '0;
          step_max = 4;
        end
        1: begin
          tmo = 32'hFFFF_FFFF;
          bo = 32'hFFFF_FFFF;
          poll = 32'hFFFF_FFFF;
          step_max = 4;
        end
        2: begin
          tmo = CONNECT_TMO_RESET;
          bo = RETRY_BACKOFF_RESET;
          poll = POLL_INTERVAL_RESET;
          step_max = 2000;
        end
        default: begin
          tmo = $urandom_range(60);
          bo = $urandom_range(60);
          poll = $urandom_range(12);
          step_max = $urandom_range(10, 2);
        end
      endcase
      if (p % 4 == 3) begin
        flags[(p / 4) % 3] = 1'b0;
        count = 20;
      end
      gaps_on = (p != 4);
      clock_ms = $urandom;
      drain();
      configure(flags, tmo, bo, poll);
      if (p == 5) begin
        run_session(count / 2, step_max);
        drain();
        run_session(count - count / 2, step_max);
      end else begin
        run_session(count, step_max);
      end
    end
    gaps_on = 1'b1;

    drain();
    repeat (8) @(negedge clk);
    $display("covered %0d result words over %0d register settings, states seen %b",
             checked, settings_used, states_seen);
    $display("connect requests %0d, disconnects %0d, mismatches %0d",
             begins_seen, disconnects_seen, errors);
    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
